### hdl/mcg_pkg.sv
// Shared types and constants for the midpoint circle generator.
package mcg_pkg;

    // Request kind carried on the input tuser bit
    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } t_kind;

    // Eight symmetric points per offset pair
    localparam int POINTS  = 8;
    localparam int PT_BITS = $clog2(POINTS);

endpackage

### hdl/mcg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-before-write: a same-cycle read returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/mcg_core.sv
// Request stage and read-modify-write of the circle state word.
module mcg_core #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 11,
    localparam int OFF_BITS   = RADIUS_BITS + 1,
    localparam int DEC_BITS   = RADIUS_BITS + 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request side
    input  logic                   i_req_valid,
    output logic                   o_req_ready,
    input  mcg_pkg::t_kind         i_req_kind,
    input  logic [COORD_BITS-1:0]  i_req_cx,
    input  logic [COORD_BITS-1:0]  i_req_cy,
    input  logic [RADIUS_BITS-1:0] i_req_rad,
    // group side
    output logic                   o_grp_valid,
    input  logic                   i_grp_ready,
    output logic [COORD_BITS-1:0]  o_grp_cx,
    output logic [COORD_BITS-1:0]  o_grp_cy,
    output logic [OFF_BITS-1:0]    o_grp_ox,
    output logic [OFF_BITS-1:0]    o_grp_oy,
    output logic                   o_grp_final
);

    // State word: {cx, cy, ox, oy, decision, active}
    localparam int SW = 2 * COORD_BITS + 2 * OFF_BITS + DEC_BITS + 1;

    localparam logic [DEC_BITS-1:0] DEC_ONE   = DEC_BITS'(1);
    localparam logic [DEC_BITS-1:0] DEC_THREE = DEC_BITS'(3);
    localparam logic [DEC_BITS-1:0] DEC_FIVE  = DEC_BITS'(5);
    localparam logic [OFF_BITS-1:0] OFF_ONE   = OFF_BITS'(1);

    // request stage
    logic                   r_s1_valid;
    mcg_pkg::t_kind         r_s1_kind;
    logic [COORD_BITS-1:0]  r_s1_cx;
    logic [COORD_BITS-1:0]  r_s1_cy;
    logic [RADIUS_BITS-1:0] r_s1_rad;

    // forwarding and written flag
    logic                   r_fwd_valid;
    logic [SW-1:0]          r_fwd_data;
    logic                   r_init;

    logic [SW-1:0]          ram_rdata;
    logic [SW-1:0]          cur;
    logic [SW-1:0]          wdata;
    logic                   we;
    logic                   s1_fire;
    logic                   makes_grp;

    logic [COORD_BITS-1:0]  cur_cx, cur_cy, new_cx, new_cy;
    logic [OFF_BITS-1:0]    cur_ox, cur_oy, new_ox, new_oy;
    logic [DEC_BITS-1:0]    cur_dec, new_dec;
    logic                   cur_act, new_act;
    logic [DEC_BITS-1:0]    two_x, two_y;

    mcg_ram #(
        .WIDTH (SW),
        .DEPTH (1)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (1'b0),
        .i_wdata (wdata),
        .i_raddr (1'b0),
        .o_rdata (ram_rdata)
    );

    // Current state: prior-cycle write, else RAM word (zero until written)
    assign cur = r_fwd_valid ? r_fwd_data : (r_init ? ram_rdata : '0);
    assign {cur_cx, cur_cy, cur_ox, cur_oy, cur_dec, cur_act} = cur;

    assign two_x = DEC_BITS'({cur_ox, 1'b0});
    assign two_y = DEC_BITS'({cur_oy, 1'b0});

    // Next state for the request in stage one
    always_comb begin
        new_cx  = cur_cx;
        new_cy  = cur_cy;
        new_ox  = cur_ox;
        new_oy  = cur_oy;
        new_dec = cur_dec;
        case (r_s1_kind)
            mcg_pkg::KIND_START: begin
                new_cx  = r_s1_cx;
                new_cy  = r_s1_cy;
                new_ox  = '0;
                new_oy  = OFF_BITS'(r_s1_rad);
                new_dec = DEC_ONE - DEC_BITS'(r_s1_rad);
            end
            mcg_pkg::KIND_STEP: begin
                new_ox = cur_ox + OFF_ONE;
                if (cur_dec[DEC_BITS-1]) begin
                    new_dec = cur_dec + two_x + DEC_THREE;
                end else begin
                    new_dec = cur_dec + two_x - two_y + DEC_FIVE;
                    new_oy  = cur_oy - OFF_ONE;
                end
            end
            default: begin
                new_ox = cur_ox;
            end
        endcase
    end

    assign new_act   = new_ox < new_oy;
    assign makes_grp = (r_s1_kind == mcg_pkg::KIND_START) || cur_act;
    assign s1_fire   = r_s1_valid && (!makes_grp || i_grp_ready);
    assign we        = s1_fire && makes_grp;
    assign wdata     = {new_cx, new_cy, new_ox, new_oy, new_dec, new_act};

    assign o_req_ready = !r_s1_valid || s1_fire;

    // Stage-one control and written-state tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_init      <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_s1_valid <= i_req_valid;
            end
            r_fwd_valid <= we;
            if (we) begin
                r_init <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_s1_kind <= i_req_kind;
            r_s1_cx   <= i_req_cx;
            r_s1_cy   <= i_req_cy;
            r_s1_rad  <= i_req_rad;
        end
        r_fwd_data <= wdata;
    end

    // Group request toward the emitter
    assign o_grp_valid = r_s1_valid && makes_grp;
    assign o_grp_cx    = new_cx;
    assign o_grp_cy    = new_cy;
    assign o_grp_ox    = new_ox;
    assign o_grp_oy    = new_oy;
    assign o_grp_final = !new_act;

endmodule

### hdl/mcg_emit.sv
// Group buffer and eight-point pixel emitter.
module mcg_emit #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 11,
    localparam int OFF_BITS   = RADIUS_BITS + 1,
    localparam int PIX_BITS   =
        ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_grp_valid,
    output logic                  o_grp_ready,
    input  logic [COORD_BITS-1:0] i_grp_cx,
    input  logic [COORD_BITS-1:0] i_grp_cy,
    input  logic [OFF_BITS-1:0]   i_grp_ox,
    input  logic [OFF_BITS-1:0]   i_grp_oy,
    input  logic                  i_grp_final,
    output logic                  o_pix_valid,
    input  logic                  i_pix_ready,
    output logic [PIX_BITS-1:0]   o_pix_x,
    output logic [PIX_BITS-1:0]   o_pix_y,
    output logic                  o_pix_last,
    output logic                  o_pix_done
);

    localparam logic [mcg_pkg::PT_BITS-1:0] PT_LAST = mcg_pkg::PT_BITS'(mcg_pkg::POINTS - 1);
    localparam logic [mcg_pkg::PT_BITS-1:0] PT_ONE  = mcg_pkg::PT_BITS'(1);

    // skid slot
    logic                  r_slot_valid;
    logic [COORD_BITS-1:0] r_slot_cx, r_slot_cy;
    logic [OFF_BITS-1:0]   r_slot_ox, r_slot_oy;
    logic                  r_slot_final;

    // emitting group
    logic                          r_em_valid;
    logic [mcg_pkg::PT_BITS-1:0]   r_em_cnt;
    logic [COORD_BITS-1:0]         r_em_cx, r_em_cy;
    logic [OFF_BITS-1:0]           r_em_ox, r_em_oy;
    logic                          r_em_final;

    logic em_done, em_load, slot_take;
    logic x_neg, y_neg;
    logic [PIX_BITS-1:0] ext_cx, ext_cy, ext_a, ext_b;

    assign em_done     = r_em_valid && i_pix_ready && (r_em_cnt == PT_LAST);
    assign em_load     = r_slot_valid && (!r_em_valid || em_done);
    assign slot_take   = i_grp_valid && o_grp_ready;
    assign o_grp_ready = !r_slot_valid || em_load;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= 1'b0;
            r_em_valid   <= 1'b0;
            r_em_cnt     <= '0;
        end else begin
            if (o_grp_ready) begin
                r_slot_valid <= i_grp_valid;
            end
            if (em_load) begin
                r_em_valid <= 1'b1;
                r_em_cnt   <= '0;
            end else if (em_done) begin
                r_em_valid <= 1'b0;
                r_em_cnt   <= '0;
            end else if (r_em_valid && i_pix_ready) begin
                r_em_cnt <= r_em_cnt + PT_ONE;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (slot_take) begin
            r_slot_cx    <= i_grp_cx;
            r_slot_cy    <= i_grp_cy;
            r_slot_ox    <= i_grp_ox;
            r_slot_oy    <= i_grp_oy;
            r_slot_final <= i_grp_final;
        end
        if (em_load) begin
            r_em_cx    <= r_slot_cx;
            r_em_cy    <= r_slot_cy;
            r_em_ox    <= r_slot_ox;
            r_em_oy    <= r_slot_oy;
            r_em_final <= r_slot_final;
        end
    end

    // Point select: odd points swap x and y; signs follow the octant order
    always_comb begin
        x_neg  = r_em_cnt inside {[2:5]};
        y_neg  = r_em_cnt inside {[4:7]};
        ext_cx = PIX_BITS'(r_em_cx);
        ext_cy = PIX_BITS'(r_em_cy);
        ext_a  = PIX_BITS'(r_em_cnt[0] ? r_em_oy : r_em_ox);
        ext_b  = PIX_BITS'(r_em_cnt[0] ? r_em_ox : r_em_oy);
    end

    assign o_pix_x     = x_neg ? (ext_cx - ext_a) : (ext_cx + ext_a);
    assign o_pix_y     = y_neg ? (ext_cy - ext_b) : (ext_cy + ext_b);
    assign o_pix_valid = r_em_valid;
    assign o_pix_last  = r_em_cnt == PT_LAST;
    assign o_pix_done  = r_em_final;

endmodule

### hdl/midpoint_circle_generator_unit.sv
// Top level of the midpoint circle generator.
//
//  Channel   Dir  Handshake                       Payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready kind, center_x, center_y, radius
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready pixel_x, pixel_y, last, done_res
//
// A start or an active step request yields eight pixels, one per cycle while
// the output is ready; the pixel emitter sets the sustained rate. A step with
// no circle in progress is absorbed without producing pixels. Synchronous
// active-low reset clears all control state; the circle state word lives in
// a one-entry RAM and reads as zero until first written. Output stalls back
// up through a one-group skid slot and the request stage to o_s_axis_tready.
module midpoint_circle_generator_unit #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 11,
    localparam int PIX_BITS   =
        ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2,
    localparam int IN_BITS    = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = ((2 * PIX_BITS + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // center_x, center_y, radius, zero pad
    input  logic [IN_BITS-1:0]  i_s_axis_tdata,
    // kind
    input  logic [0:0]          i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // pixel_x, pixel_y, zero pad
    output logic [OUT_BITS-1:0] o_m_axis_tdata,
    output logic                o_m_axis_tlast,
    // done_res
    output logic [0:0]          o_m_axis_tuser
);

    localparam int OFF_BITS = RADIUS_BITS + 1;

    logic                  grp_valid, grp_ready, grp_final;
    logic [COORD_BITS-1:0] grp_cx, grp_cy;
    logic [OFF_BITS-1:0]   grp_ox, grp_oy;
    logic [PIX_BITS-1:0]   pix_x, pix_y;
    logic                  pix_done;

    mcg_core #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req_kind  (mcg_pkg::t_kind'(i_s_axis_tuser[0])),
        .i_req_cx    (i_s_axis_tdata[COORD_BITS-1:0]),
        .i_req_cy    (i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_req_rad   (i_s_axis_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
        .o_grp_valid (grp_valid),
        .i_grp_ready (grp_ready),
        .o_grp_cx    (grp_cx),
        .o_grp_cy    (grp_cy),
        .o_grp_ox    (grp_ox),
        .o_grp_oy    (grp_oy),
        .o_grp_final (grp_final)
    );

    mcg_emit #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .o_grp_ready (grp_ready),
        .i_grp_cx    (grp_cx),
        .i_grp_cy    (grp_cy),
        .i_grp_ox    (grp_ox),
        .i_grp_oy    (grp_oy),
        .i_grp_final (grp_final),
        .o_pix_valid (o_m_axis_tvalid),
        .i_pix_ready (i_m_axis_tready),
        .o_pix_x     (pix_x),
        .o_pix_y     (pix_y),
        .o_pix_last  (o_m_axis_tlast),
        .o_pix_done  (pix_done)
    );

    // Pack output fields, lowest first
    assign o_m_axis_tdata = OUT_BITS'({pix_y, pix_x});
    assign o_m_axis_tuser = pix_done;

endmodule
